### rtl/bksf_pkg.sv
// ----------------------------------------------------------------------------
// bksf_pkg
// Shared types and constants of the knot span finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bksf_pkg;

  localparam int MAX_KNOTS_DEF  = 64;
  localparam int KNOT_WIDTH_DEF = 32;

  localparam int SPAN_W   = 6;
  localparam int STATUS_W = 2;
  localparam int DEGREE_W = 4;

  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND    = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_FEW      = 2'd3
  } status_t;

  // query token flags handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic low;
  } tok_flags_t;

endpackage

`default_nettype wire

### rtl/bksf_if.sv
// ----------------------------------------------------------------------------
// bksf_if
// Channel interfaces of the knot span finder: items, results and degree.
// ----------------------------------------------------------------------------
`default_nettype none

interface bksf_item_if #(
  parameter int KnotWidth = bksf_pkg::KNOT_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [KnotWidth-1:0] knot_value;
  logic signed [KnotWidth-1:0] param_u;

  modport source (output valid, command, knot_value, param_u, input ready);
  modport sink   (input valid, command, knot_value, param_u, output ready);
endinterface

interface bksf_result_if ();
  logic                          valid;
  logic                          ready;
  logic [bksf_pkg::SPAN_W-1:0]   span_index;
  logic [bksf_pkg::STATUS_W-1:0] status;

  modport source (output valid, span_index, status, input ready);
  modport sink   (input valid, span_index, status, output ready);
endinterface

interface bksf_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [bksf_pkg::DEGREE_W-1:0] spline_degree;

  modport source (output valid, spline_degree, input ready);
  modport sink   (input valid, spline_degree, output ready);
endinterface

`default_nettype wire

### rtl/bksf_cell.sv
// ----------------------------------------------------------------------------
// bksf_cell
// One knot slot: sorted insert against its lower neighbour, and one stage
// of the query token that walks the row.
// ----------------------------------------------------------------------------
`default_nettype none

module bksf_cell #(
  parameter int KnotWidth = bksf_pkg::KNOT_WIDTH_DEF,
  parameter int IdxW      = 6,
  parameter int CntW      = 7,
  parameter int CellIdx   = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [CntW-1:0]               count,
  input  wire logic [bksf_pkg::DEGREE_W-1:0] degree,
  input  wire logic                          ins_en,
  input  wire logic signed [KnotWidth-1:0]   ins_value,
  input  wire logic signed [KnotWidth-1:0]   prev_knot,
  input  wire logic                          prev_shift,
  output logic signed [KnotWidth-1:0]        knot,
  output logic                               shift,
  input  wire bksf_pkg::tok_flags_t          tok_in,
  input  wire logic signed [KnotWidth-1:0]   u_in,
  input  wire logic [IdxW-1:0]               span_in,
  output bksf_pkg::tok_flags_t               tok_out,
  output logic signed [KnotWidth-1:0]        u_out,
  output logic [IdxW-1:0]                    span_out
);
  import bksf_pkg::*;

  localparam logic [IdxW-1:0] MY_IDX = IdxW'(CellIdx);

  logic occupied;
  logic at_end;
  logic is_degree;
  logic le_u;

  assign occupied  = (CellIdx < int'(count));
  assign at_end    = (CellIdx == int'(count));
  assign is_degree = (CellIdx == int'(degree));
  assign shift     = occupied && (knot >= ins_value);
  assign le_u      = occupied && (knot <= u_in);

  // entries not less than the new knot move up one place
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (prev_shift) begin
        knot <= prev_knot;
      end else if (shift || at_end) begin
        knot <= ins_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | le_u;
      tok_out.low   <= tok_in.low | (is_degree && (knot >= u_in));
    end
  end

  always_ff @(posedge clk) begin
    u_out    <= u_in;
    span_out <= le_u ? MY_IDX : span_in;
  end

endmodule

`default_nettype wire

### rtl/bspline_knot_span_finder_unit.sv
// ----------------------------------------------------------------------------
// bspline_knot_span_finder_unit
// Sorted knot store with span lookup, built as a row of knot cells.
// ----------------------------------------------------------------------------
// Channels: item (sink) carries command, knot_value and param_u; result
// (source) carries span_index and status; cfg (sink) writes spline_degree,
// ready whenever reset is low. Every item gives exactly one result transfer.
// An insert, a full-store answer and a too-few-knots answer load the output
// register at the item transfer edge, so such items can follow back to back
// while the receiver keeps up.
// A span query sends a token through the row of MAX_KNOTS cells, one cell
// per cycle; the clamp at the row exit is combinational and its answer is
// registered, then loaded into the output register once that is free; the
// next item is taken at the earliest at the edge where the result transfers.
// One item is in work at a time; item.ready is high outside reset while no
// query is in flight and the output register is empty or being taken.
// When the receiver stalls, the result holds in the output register, and a
// finished query holds its clamped answer until the register frees up.
// Reset empties the store (count zero), sets the degree to 3 and drops any
// token in flight; knot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_knot_span_finder_unit #(
  parameter int MAX_KNOTS  = bksf_pkg::MAX_KNOTS_DEF,
  parameter int KNOT_WIDTH = bksf_pkg::KNOT_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bksf_item_if.sink     item,
  bksf_result_if.source result,
  bksf_cfg_if.sink      cfg
);
  import bksf_pkg::*;

  localparam int IDX_W = $clog2(MAX_KNOTS);
  localparam int CNT_W = $clog2(MAX_KNOTS + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_KNOTS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic [DEGREE_W-1:0] degree;

  logic [SPAN_W-1:0] res_span;
  status_t           res_status;

  logic out_free;
  logic accept;
  logic is_insert;
  logic is_full;
  logic is_few;
  logic ins_en;
  logic start_query;

  logic signed [KNOT_WIDTH-1:0] knot_w [MAX_KNOTS];
  logic                         shift_w [MAX_KNOTS];
  tok_flags_t                   tok_w [MAX_KNOTS+1];
  logic signed [KNOT_WIDTH-1:0] u_w [MAX_KNOTS+1];
  logic [IDX_W-1:0]             span_w [MAX_KNOTS+1];

  logic [CNT_W-1:0]        dof;
  logic [IDX_W-1:0]        span_sel;
  logic [IDX_W+SPAN_W-1:0] span_ext;
  logic [SPAN_W-1:0]       done_span;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_RESET;
    end else if (cfg.valid) begin
      degree <= cfg.spline_degree;
    end
  end

  assign out_free    = !result.valid || result.ready;
  assign item.ready  = !rst && (state == ST_IDLE) && out_free;
  assign accept      = item.valid && item.ready;
  assign is_insert   = (item.command == CMD_INSERT);
  assign is_full     = (count == FULL_COUNT);
  assign is_few      = int'(count) < (2 * int'(degree) + 2);
  assign ins_en      = accept && is_insert && !is_full;
  assign start_query = accept && !is_insert && !is_few;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // row of knot cells
  assign tok_w[0]  = {start_query, 1'b0, 1'b0};
  assign u_w[0]    = item.param_u;
  assign span_w[0] = '0;

  for (genvar i = 0; i < MAX_KNOTS; i++) begin : g_cell
    logic signed [KNOT_WIDTH-1:0] prev_knot;
    logic                         prev_shift;

    if (i == 0) begin : g_first
      assign prev_knot  = '0;
      assign prev_shift = 1'b0;
    end else begin : g_rest
      assign prev_knot  = knot_w[i-1];
      assign prev_shift = shift_w[i-1];
    end

    bksf_cell #(
      .KnotWidth (KNOT_WIDTH),
      .IdxW      (IDX_W),
      .CntW      (CNT_W),
      .CellIdx   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count      (count),
      .degree     (degree),
      .ins_en     (ins_en),
      .ins_value  (item.knot_value),
      .prev_knot  (prev_knot),
      .prev_shift (prev_shift),
      .knot       (knot_w[i]),
      .shift      (shift_w[i]),
      .tok_in     (tok_w[i]),
      .u_in       (u_w[i]),
      .span_in    (span_w[i]),
      .tok_out    (tok_w[i+1]),
      .u_out      (u_w[i+1]),
      .span_out   (span_w[i+1])
    );
  end

  // clamp at the row exit
  assign dof = count - CNT_W'(degree) - CNT_W'(1);

  always_comb begin
    priority if (tok_w[MAX_KNOTS].found && (CNT_W'(span_w[MAX_KNOTS]) >= dof)) begin
      span_sel = IDX_W'(dof - CNT_W'(1));
    end else if (tok_w[MAX_KNOTS].low) begin
      span_sel = IDX_W'(degree);
    end else begin
      span_sel = span_w[MAX_KNOTS];
    end
  end

  assign span_ext = {{SPAN_W{1'b0}}, span_sel};

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && tok_w[MAX_KNOTS].valid) begin
      done_span <= span_ext[SPAN_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_query) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_w[MAX_KNOTS].valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && !start_query) begin
      result.valid <= 1'b1;
    end else if (state == ST_DONE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start_query) begin
      res_span <= '0;
      priority if (is_insert && is_full) begin
        res_status <= STAT_FULL;
      end else if (is_insert) begin
        res_status <= STAT_INSERTED;
      end else begin
        res_status <= STAT_FEW;
      end
    end else if (state == ST_DONE && out_free) begin
      res_span   <= done_span;
      res_status <= STAT_FOUND;
    end
  end

  assign result.span_index = res_span;
  assign result.status     = res_status;

endmodule

`default_nettype wire
